[sv/motion_reaction_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// motion_reaction_sequencer assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTION_REACTION_SEQUENCER_MACROS_SVH
`define MOTION_REACTION_SEQUENCER_MACROS_SVH

// property must hold at every edge out of reset
`define MRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true out of reset
`define MRS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[sv/mrs_pkg.sv]
// ----------------------------------------------------------------------------
// mrs_pkg
// Types, codes and constants of the motion reaction sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

  typedef struct packed {
    logic        [31:0] now_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } mrs_in_t;

  typedef struct packed {
    logic [2:0] reaction;
    logic       active;
  } mrs_out_t;

  typedef struct packed {
    logic [14:0] gravity_base;
    logic [14:0] mild_rate_lim;
    logic [14:0] mild_acc_lim;
    logic [14:0] hard_rate_lim;
    logic [14:0] hard_acc_lim;
    logic [14:0] top_rate_lim;
    logic [14:0] top_acc_lim;
    logic [15:0] cooldown_ms;
  } mrs_cfg_t;

  typedef struct packed {
    logic mild;
    logic hard;
    logic calm_up;
    logic settled;
  } mrs_flags_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_EXCITED = 3'd1,
    PH_TILT    = 3'd2,
    PH_DROP    = 3'd3,
    PH_PEAK    = 3'd4,
    PH_DIZZY   = 3'd5,
    PH_HAPPY   = 3'd6
  } mrs_phase_e;

  typedef enum logic [2:0] {
    CFG_GRAVITY_BASE  = 3'd0,
    CFG_MILD_RATE_LIM = 3'd1,
    CFG_MILD_ACC_LIM  = 3'd2,
    CFG_HARD_RATE_LIM = 3'd3,
    CFG_HARD_ACC_LIM  = 3'd4,
    CFG_TOP_RATE_LIM  = 3'd5,
    CFG_TOP_ACC_LIM   = 3'd6,
    CFG_COOLDOWN_MS   = 3'd7
  } mrs_cfg_idx_e;

  typedef enum logic [1:0] {
    CT_IDLE = 2'd0,
    CT_RUN  = 2'd1,
    CT_DONE = 2'd2
  } mrs_ctl_e;

  typedef enum logic [1:0] {
    CL_IDLE   = 2'd0,
    CL_LAUNCH = 2'd1,
    CL_BUSY   = 2'd2
  } mrs_cls_e;

  typedef enum logic [4:0] {
    J_AX   = 5'd0,
    J_AY   = 5'd1,
    J_AZ   = 5'd2,
    J_GX   = 5'd3,
    J_GY   = 5'd4,
    J_GZ   = 5'd5,
    J_TILT = 5'd6,
    J_TG   = 5'd7,
    J_SG   = 5'd8,
    J_TDH  = 5'd9,
    J_TDL  = 5'd10,
    J_SDH  = 5'd11,
    J_SDL  = 5'd12,
    J_CAH  = 5'd13,
    J_CAL  = 5'd14,
    J_SAH  = 5'd15,
    J_SAL  = 5'd16
  } mrs_job_e;

  localparam logic [29:0] COS12_SQ_Q30  = 30'd1027326895;
  localparam logic [31:0] CALM_G_SQ     = 32'd19881;
  localparam logic [31:0] SETTLED_G_SQ  = 32'd589824;
  localparam logic [14:0] CALM_A        = 15'd205;
  localparam logic [14:0] SETTLED_A     = 15'd640;

  localparam logic [31:0] DW_EXCITED    = 32'd200;
  localparam logic [31:0] DW_TILT       = 32'd200;
  localparam logic [31:0] DW_SETTLE     = 32'd400;
  localparam logic [31:0] DW_DROP       = 32'd200;
  localparam logic [31:0] DW_PEAK_MIN   = 32'd400;
  localparam logic [31:0] DW_PEAK_MAX   = 32'd1000;
  localparam logic [31:0] DW_DIZZY      = 32'd700;
  localparam logic [31:0] DW_HAPPY      = 32'd800;
  localparam logic [31:0] COOL_END_RST  = 32'd500;

  localparam mrs_cfg_t CFG_RST = '{
    gravity_base:  15'd2637,
    mild_rate_lim: 15'd205,
    mild_acc_lim:  15'd230,
    hard_rate_lim: 15'd1024,
    hard_acc_lim:  15'd640,
    top_rate_lim:  15'd1920,
    top_acc_lim:   15'd1408,
    cooldown_ms:   16'd700
  };

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] r;
    r = v[15] ? 16'(-v) : 16'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/mrs_dmul.sv]
// ----------------------------------------------------------------------------
// mrs_dmul
// Digit-serial multiplier: 30-bit operand times 8-bit digits of a 32-bit
// operand, two or four digits, one partial product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrs_dmul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        long_i,
  input  wire logic [29:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [61:0]      prod_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  last_q, last_d;
  logic [29:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [61:0] p_q, p_d;
  logic [37:0] pp;

  assign pp = {8'd0, a_q} * {30'd0, b_q[7:0]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    last_d = last_q;
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      last_d = long_i ? 2'd3 : 2'd1;
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
    end else if (busy_q) begin
      p_d   = p_q + ({24'd0, pp} << {cnt_q, 3'b000});
      b_d   = b_q >> 8;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == last_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
      last_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

[sv/mrs_class.sv]
// ----------------------------------------------------------------------------
// mrs_class
// Sample classifier: squared magnitudes and squared thresholds through the
// shared digit-serial multiplier, compared one job at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrs_class (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire mrs_pkg::mrs_in_t  sample_i,
  input  wire mrs_pkg::mrs_cfg_t cfg_i,
  output logic                   done_o,
  output mrs_pkg::mrs_flags_t    flags_o
);

  import mrs_pkg::*;

  mrs_cls_e    st_q, st_d;
  mrs_job_e    job_q, job_d, lj;
  mrs_in_t     smp_q, smp_d;
  logic        done_q, done_d;
  logic        mul_start, mul_long, mul_done, act;
  logic [29:0] mul_a;
  logic [31:0] mul_b;
  logic [61:0] prod;
  logic [31:0] p32;
  logic [15:0] op16, g16;
  logic [15:0] td_hi, td_lo, sd_hi, sd_lo, ca_hi, ca_lo, sa_hi, sa_lo;
  logic [61:0] ysq30;
  logic        y_pos;

  logic [31:0] asq_q, asq_d, gsq_q, gsq_d;
  logic [30:0] ysq_q, ysq_d;
  logic        tilted_q, tilted_d, upright_q, upright_d;
  logic        mild_g_q, mild_g_d, mild_a_q, mild_a_d;
  logic        strong_g_q, strong_g_d, strong_a_q, strong_a_d;
  logic        calm_a_q, calm_a_d, set_a_q, set_a_d;

  mrs_dmul u_dmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .long_i  (mul_long),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign g16   = {1'b0, cfg_i.gravity_base};
  assign td_hi = g16 + {1'b0, cfg_i.mild_acc_lim};
  assign td_lo = g16 - {1'b0, cfg_i.mild_acc_lim};
  assign sd_hi = g16 + {1'b0, cfg_i.hard_acc_lim};
  assign sd_lo = g16 - {1'b0, cfg_i.hard_acc_lim};
  assign ca_hi = g16 + {1'b0, CALM_A};
  assign ca_lo = g16 - {1'b0, CALM_A};
  assign sa_hi = g16 + {1'b0, SETTLED_A};
  assign sa_lo = g16 - {1'b0, SETTLED_A};

  assign lj = (st_q == CL_LAUNCH) ? job_q : mrs_job_e'(5'(job_q + 5'd1));

  always_comb begin
    op16     = '0;
    mul_long = 1'b0;
    unique case (lj)
      J_AX:    op16 = abs16(smp_q.accel_x);
      J_AY:    op16 = abs16(smp_q.accel_y);
      J_AZ:    op16 = abs16(smp_q.accel_z);
      J_GX:    op16 = abs16(smp_q.gyro_x);
      J_GY:    op16 = abs16(smp_q.gyro_y);
      J_GZ:    op16 = abs16(smp_q.gyro_z);
      J_TILT:  mul_long = 1'b1;
      J_TG:    op16 = {1'b0, cfg_i.mild_rate_lim};
      J_SG:    op16 = {1'b0, cfg_i.hard_rate_lim};
      J_TDH:   op16 = td_hi;
      J_TDL:   op16 = td_lo;
      J_SDH:   op16 = sd_hi;
      J_SDL:   op16 = sd_lo;
      J_CAH:   op16 = ca_hi;
      J_CAL:   op16 = ca_lo;
      J_SAH:   op16 = sa_hi;
      J_SAL:   op16 = sa_lo;
      default: op16 = '0;
    endcase
    mul_a = mul_long ? COS12_SQ_Q30 : {14'd0, op16};
    mul_b = mul_long ? asq_q : {16'd0, op16};
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      CL_IDLE:   if (start_i) st_d = CL_LAUNCH;
      CL_LAUNCH: st_d = CL_BUSY;
      CL_BUSY:   if (mul_done && job_q == J_SAL) st_d = CL_IDLE;
      default:   st_d = CL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    act       = (st_q == CL_BUSY) && mul_done;
    mul_start = (st_q == CL_LAUNCH) || (act && job_q != J_SAL);
    done_d    = act && job_q == J_SAL;
  end

  assign p32   = prod[31:0];
  assign ysq30 = {1'b0, ysq_q, 30'd0};
  assign y_pos = !smp_q.accel_y[15] && (smp_q.accel_y != '0);

  always_comb begin
    smp_d      = smp_q;
    job_d      = job_q;
    asq_d      = asq_q;
    gsq_d      = gsq_q;
    ysq_d      = ysq_q;
    tilted_d   = tilted_q;
    upright_d  = upright_q;
    mild_g_d   = mild_g_q;
    mild_a_d   = mild_a_q;
    strong_g_d = strong_g_q;
    strong_a_d = strong_a_q;
    calm_a_d   = calm_a_q;
    set_a_d    = set_a_q;
    if (st_q == CL_IDLE && start_i) begin
      smp_d = sample_i;
      job_d = J_AX;
    end
    if (act) begin
      if (job_q != J_SAL) job_d = mrs_job_e'(5'(job_q + 5'd1));
      unique case (job_q)
        J_AX:   asq_d = p32;
        J_AY: begin
          asq_d = asq_q + p32;
          ysq_d = p32[30:0];
        end
        J_AZ:   asq_d = asq_q + p32;
        J_GX:   gsq_d = p32;
        J_GY:   gsq_d = gsq_q + p32;
        J_GZ:   gsq_d = gsq_q + p32;
        J_TILT: begin
          tilted_d  = (asq_q != '0) && (smp_q.accel_y[15] || ysq30 < prod);
          upright_d = (asq_q == '0) || (y_pos && ysq30 > prod);
        end
        J_TG:   mild_g_d   = gsq_q > p32;
        J_SG:   strong_g_d = gsq_q > p32;
        J_TDH:  mild_a_d   = asq_q > p32;
        J_TDL:  mild_a_d   = mild_a_q ||
                             (cfg_i.gravity_base > cfg_i.mild_acc_lim && asq_q < p32);
        J_SDH:  strong_a_d = asq_q > p32;
        J_SDL:  strong_a_d = strong_a_q ||
                             (cfg_i.gravity_base > cfg_i.hard_acc_lim && asq_q < p32);
        J_CAH:  calm_a_d   = asq_q < p32;
        J_CAL:  calm_a_d   = calm_a_q && (cfg_i.gravity_base < CALM_A || asq_q > p32);
        J_SAH:  set_a_d    = asq_q < p32;
        J_SAL:  set_a_d    = set_a_q && (cfg_i.gravity_base < SETTLED_A || asq_q > p32);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= CL_IDLE;
      job_q  <= J_AX;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      job_q  <= job_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q      <= smp_d;
    asq_q      <= asq_d;
    gsq_q      <= gsq_d;
    ysq_q      <= ysq_d;
    tilted_q   <= tilted_d;
    upright_q  <= upright_d;
    mild_g_q   <= mild_g_d;
    mild_a_q   <= mild_a_d;
    strong_g_q <= strong_g_d;
    strong_a_q <= strong_a_d;
    calm_a_q   <= calm_a_d;
    set_a_q    <= set_a_d;
  end

  assign done_o          = done_q;
  assign flags_o.mild    = mild_g_q || mild_a_q || tilted_q;
  assign flags_o.hard    = strong_g_q || strong_a_q;
  assign flags_o.calm_up = (gsq_q < CALM_G_SQ) && calm_a_q && upright_q;
  assign flags_o.settled = (gsq_q < SETTLED_G_SQ) && set_a_q;

endmodule

`default_nettype wire

[sv/mrs_phase.sv]
// ----------------------------------------------------------------------------
// mrs_phase
// Reaction sequence: phase, dwell and settle timers, strong latch, cooldown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrs_phase (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                commit_i,
  input  wire logic [31:0]         now_i,
  input  wire mrs_pkg::mrs_flags_t flags_i,
  input  wire logic [15:0]         cooldown_i,
  output mrs_pkg::mrs_phase_e      phase_o
);

  import mrs_pkg::*;

  mrs_phase_e  phase_q, phase_d;
  logic [31:0] enter_q, enter_d, sstart_q, sstart_d, cend_q, cend_d;
  logic        svalid_q, svalid_d, sseen_q, sseen_d;
  logic [31:0] dwell, sdur, cdiff;
  logic        seen_now, settle_set, settle_clr, happy_exit;

  assign dwell    = now_i - enter_q;
  assign sdur     = now_i - sstart_q;
  assign cdiff    = now_i - cend_q;
  assign seen_now = sseen_q || flags_i.hard;

  // next state
  always_comb begin
    phase_d    = phase_q;
    settle_set = 1'b0;
    settle_clr = 1'b0;
    happy_exit = 1'b0;
    unique case (phase_q)
      PH_IDLE:    if (!cdiff[31] && flags_i.mild) phase_d = PH_EXCITED;
      PH_EXCITED: if (dwell >= DW_EXCITED) phase_d = PH_TILT;
      PH_TILT: begin
        if (seen_now && dwell >= DW_TILT) begin
          phase_d = PH_DROP;
        end else if (flags_i.calm_up) begin
          if (!svalid_q) settle_set = 1'b1;
          else if (sdur >= DW_SETTLE) phase_d = PH_HAPPY;
        end else begin
          settle_clr = 1'b1;
        end
      end
      PH_DROP:    if (dwell >= DW_DROP) phase_d = PH_PEAK;
      PH_PEAK: begin
        if (dwell >= DW_PEAK_MIN && (flags_i.settled || dwell >= DW_PEAK_MAX))
          phase_d = PH_DIZZY;
      end
      PH_DIZZY:   if (dwell >= DW_DIZZY) phase_d = PH_HAPPY;
      PH_HAPPY: begin
        if (dwell >= DW_HAPPY) begin
          phase_d    = PH_IDLE;
          happy_exit = 1'b1;
        end
      end
      default:    phase_d = PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    phase_o = phase_d;
  end

  always_comb begin
    enter_d  = enter_q;
    sstart_d = sstart_q;
    svalid_d = svalid_q;
    cend_d   = cend_q;
    sseen_d  = seen_now;
    if (phase_q == PH_IDLE && phase_d == PH_EXCITED) sseen_d = flags_i.hard;
    if (happy_exit) begin
      sseen_d = 1'b0;
      cend_d  = now_i + {16'd0, cooldown_i};
    end
    if (phase_d != phase_q) begin
      enter_d  = now_i;
      svalid_d = 1'b0;
    end else if (settle_set) begin
      svalid_d = 1'b1;
      sstart_d = now_i;
    end else if (settle_clr) begin
      svalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      enter_q  <= '0;
      svalid_q <= 1'b0;
      cend_q   <= COOL_END_RST;
      sseen_q  <= 1'b0;
    end else if (commit_i) begin
      phase_q  <= phase_d;
      enter_q  <= enter_d;
      svalid_q <= svalid_d;
      cend_q   <= cend_d;
      sseen_q  <= sseen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) sstart_q <= sstart_d;
  end

endmodule

`default_nettype wire

[sv/motion_reaction_sequencer.sv]
// ----------------------------------------------------------------------------
// motion_reaction_sequencer
// Classifies IMU samples and steps a seven-phase reaction sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one IMU sample beat (timestamp, accel, gyro) per valid/ready.
//   out_*  : one result beat per sample: reaction phase and active flag.
//   cfg_*  : register write port, one write per cycle with cfg_we_i high,
//            only while no sample is in flight.
// The shared digit-serial multiplier runs 16 squaring jobs and one tilt
//   product per sample, one 8-bit digit per cycle; done, control and output
//   registers follow.
// One sample is in work at a time; the next beat waits until its result is committed.
// A finished result waits in the output register; the next sample is taken
//   and classified meanwhile, and its result waits until out_ready_i frees
//   the register.
// Reset: phase idle, cooldown end at 500 ms, configuration registers at their
//   defaults, output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "motion_reaction_sequencer_macros.svh"

module motion_reaction_sequencer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire mrs_pkg::mrs_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output mrs_pkg::mrs_out_t     out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [15:0]      cfg_wdata_i
);

  import mrs_pkg::*;

  mrs_ctl_e   ctl_q, ctl_d;
  mrs_cfg_t   cfg_q, cfg_d;
  mrs_flags_t flags;
  mrs_phase_e phase_nxt;
  mrs_out_t   out_q;
  logic       out_valid_q;
  logic       accept, cls_done, commit;
  logic [31:0] now_q;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (mrs_cfg_idx_e'(cfg_idx_i))
        CFG_GRAVITY_BASE:  cfg_d.gravity_base  = cfg_wdata_i[14:0];
        CFG_MILD_RATE_LIM: cfg_d.mild_rate_lim = cfg_wdata_i[14:0];
        CFG_MILD_ACC_LIM:  cfg_d.mild_acc_lim  = cfg_wdata_i[14:0];
        CFG_HARD_RATE_LIM: cfg_d.hard_rate_lim = cfg_wdata_i[14:0];
        CFG_HARD_ACC_LIM:  cfg_d.hard_acc_lim  = cfg_wdata_i[14:0];
        CFG_TOP_RATE_LIM:  cfg_d.top_rate_lim  = cfg_wdata_i[14:0];
        CFG_TOP_ACC_LIM:   cfg_d.top_acc_lim   = cfg_wdata_i[14:0];
        CFG_COOLDOWN_MS:   cfg_d.cooldown_ms   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CT_IDLE: if (accept) ctl_d = CT_RUN;
      CT_RUN:  if (cls_done) ctl_d = CT_DONE;
      CT_DONE: if (!out_valid_q || out_ready_i) ctl_d = CT_IDLE;
      default: ctl_d = CT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = (ctl_q == CT_IDLE);
    commit     = (ctl_q == CT_DONE) && (!out_valid_q || out_ready_i);
  end

  mrs_class u_class (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (in_data_i),
    .cfg_i    (cfg_q),
    .done_o   (cls_done),
    .flags_o  (flags)
  );

  mrs_phase u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (commit),
    .now_i      (now_q),
    .flags_i    (flags),
    .cooldown_i (cfg_q.cooldown_ms),
    .phase_o    (phase_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= CT_IDLE;
      cfg_q       <= CFG_RST;
      out_valid_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      cfg_q <= cfg_d;
      if (commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) now_q <= in_data_i.now_ms;
    if (commit) begin
      out_q.reaction <= phase_nxt;
      out_q.active   <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MRS_NEVER(a_no_overwrite, commit && out_valid_q && !out_ready_i, "result overwritten")
  `MRS_ASSERT(a_done_in_run, cls_done |-> ctl_q == CT_RUN, "classifier done outside run")
  `MRS_ASSERT(a_rise_after_commit, $rose(out_valid_o) |-> $past(commit), "result without commit")
  `MRS_ASSERT(a_active, out_valid_o |-> out_data_o.active == (out_data_o.reaction != PH_IDLE), "bad active")

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Motion reaction sequencer testbench
// Drives IMU sample beats through a directed table and then random reaction
// sequences, predicts each result beat and compares it with the output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mrs_pkg::*;

  typedef struct {
    mrs_in_t    smp;
    logic       known;
    mrs_phase_e phase;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  mrs_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mrs_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  motion_reaction_sequencer u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mrs_cfg_t   regs;
  mrs_phase_e cur_phase;
  logic [31:0] enter_ms, settle_ms, cool_end_ms;
  logic        settle_on, strong_latch;
  mrs_out_t    pending_reactions[$];
  int unsigned mismatches = 0, beats_checked = 0, fed = 0;
  logic [31:0] clock_ms = 0;
  logic        stall_mode = 1'b0;

  function automatic logic [63:0] sq(input logic [31:0] t);
    return 64'(t) * 64'(t);
  endfunction

  function automatic logic [63:0] sum_sq(input logic signed [15:0] a, b, c);
    logic signed [31:0] wa, wb, wc;
    wa = 32'(a);
    wb = 32'(b);
    wc = 32'(c);
    return 64'(wa * wa) + 64'(wb * wb) + 64'(wc * wc);
  endfunction

  function automatic logic dev_above(input logic [63:0] asq, input logic [31:0] g, d);
    if (asq > sq(g + d)) return 1'b1;
    return g > d && asq < sq(g - d);
  endfunction

  function automatic logic dev_below(input logic [63:0] asq, input logic [31:0] g, c);
    if (!(asq < sq(g + c))) return 1'b0;
    return g < c || asq > sq(g - c);
  endfunction

  task automatic move_to(input mrs_phase_e nxt, input logic [31:0] now);
    if (nxt != cur_phase) begin
      cur_phase = nxt;
      enter_ms = now;
      settle_on = 1'b0;
      settle_ms = '0;
    end
  endtask

  task automatic reset_model();
    regs = CFG_RST;
    cur_phase = PH_IDLE;
    enter_ms = '0;
    settle_ms = '0;
    settle_on = 1'b0;
    cool_end_ms = 32'd500;
    strong_latch = 1'b0;
  endtask

  task automatic predict_reaction(input mrs_in_t s);
    logic [63:0]  asq, gsq, ref_q, ysq_q30;
    logic [127:0] wide;
    logic [31:0]  now, dwell;
    logic signed [31:0] y32;
    logic tilted, upright, mild, hard, calm, settled;
    mrs_out_t r;
    now = s.now_ms;
    asq = sum_sq(s.accel_x, s.accel_y, s.accel_z);
    gsq = sum_sq(s.gyro_x, s.gyro_y, s.gyro_z);
    y32 = 32'(s.accel_y);
    ysq_q30 = 64'(y32 * y32) << 30;
    wide = 128'(64'd1027326895) * 128'(asq);
    ref_q = wide[63:0];
    tilted = asq != 0 && (s.accel_y < 0 || ysq_q30 < ref_q);
    upright = asq == 0 || (s.accel_y > 0 && ysq_q30 > ref_q);
    mild = gsq > sq(regs.mild_rate_lim) || tilted ||
           dev_above(asq, regs.gravity_base, regs.mild_acc_lim);
    hard = gsq > sq(regs.hard_rate_lim) ||
           dev_above(asq, regs.gravity_base, regs.hard_acc_lim);
    calm = gsq < sq(141) && dev_below(asq, regs.gravity_base, 205);
    settled = gsq < sq(768) && dev_below(asq, regs.gravity_base, 640);
    dwell = now - enter_ms;
    if (hard) strong_latch = 1'b1;
    case (cur_phase)
      PH_IDLE: begin
        if ($signed(now - cool_end_ms) >= 0 && mild) begin
          strong_latch = hard;
          move_to(PH_EXCITED, now);
        end
      end
      PH_EXCITED: if (dwell >= 200) move_to(PH_TILT, now);
      PH_TILT: begin
        if (strong_latch && dwell >= 200) begin
          move_to(PH_DROP, now);
        end else if (calm && upright) begin
          if (!settle_on) begin
            settle_on = 1'b1;
            settle_ms = now;
          end else if (now - settle_ms >= 400) begin
            move_to(PH_HAPPY, now);
          end
        end else begin
          settle_on = 1'b0;
          settle_ms = '0;
        end
      end
      PH_DROP: if (dwell >= 200) move_to(PH_PEAK, now);
      PH_PEAK: if (dwell >= 400 && (settled || dwell >= 1000)) move_to(PH_DIZZY, now);
      PH_DIZZY: if (dwell >= 700) move_to(PH_HAPPY, now);
      PH_HAPPY: begin
        if (dwell >= 800) begin
          cur_phase = PH_IDLE;
          enter_ms = now;
          settle_on = 1'b0;
          settle_ms = '0;
          strong_latch = 1'b0;
          cool_end_ms = now + regs.cooldown_ms;
        end
      end
      default: cur_phase = PH_IDLE;
    endcase
    r.reaction = cur_phase;
    r.active = cur_phase != PH_IDLE;
    pending_reactions.push_back(r);
  endtask

  task automatic send_beat(input mrs_in_t s);
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reaction(s);
    fed++;
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_reactions.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input mrs_cfg_idx_e idx, input logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_GRAVITY_BASE:  regs.gravity_base = v[14:0];
      CFG_MILD_RATE_LIM: regs.mild_rate_lim = v[14:0];
      CFG_MILD_ACC_LIM:  regs.mild_acc_lim = v[14:0];
      CFG_HARD_RATE_LIM: regs.hard_rate_lim = v[14:0];
      CFG_HARD_ACC_LIM:  regs.hard_acc_lim = v[14:0];
      CFG_TOP_RATE_LIM:  regs.top_rate_lim = v[14:0];
      CFG_TOP_ACC_LIM:   regs.top_acc_lim = v[14:0];
      CFG_COOLDOWN_MS:   regs.cooldown_ms = v;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] near(input int base, input int spread);
    return 16'(base + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Sample biased toward the thresholds so the phase sequence gets exercised
  function automatic mrs_in_t make_sample(input int unsigned kind);
    mrs_in_t s;
    s.now_ms = '0;
    case (kind)
      0: begin
        s.accel_x = near(0, 60);   s.accel_y = near(2637, 120); s.accel_z = near(0, 60);
        s.gyro_x = near(0, 60);    s.gyro_y = near(0, 60);      s.gyro_z = near(0, 60);
      end
      1: begin
        s.accel_x = near(0, 300);  s.accel_y = near(2637, 400); s.accel_z = near(0, 300);
        s.gyro_x = near(0, 400);   s.gyro_y = near(0, 400);     s.gyro_z = near(0, 400);
      end
      2: begin
        s.accel_x = near(0, 2000); s.accel_y = near(2000, 2500); s.accel_z = near(0, 2000);
        s.gyro_x = near(0, 1500);  s.gyro_y = near(0, 1500);    s.gyro_z = near(0, 1500);
      end
      default: begin
        s.accel_x = 16'($urandom); s.accel_y = 16'($urandom); s.accel_z = 16'($urandom);
        s.gyro_x = 16'($urandom);  s.gyro_y = 16'($urandom);  s.gyro_z = 16'($urandom);
      end
    endcase
    return s;
  endfunction

  task automatic random_phase(input int unsigned n);
    mrs_in_t s;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      s = make_sample(r < 45 ? 0 : r < 75 ? 1 : r < 92 ? 2 : 3);
      r = $urandom_range(0, 99);
      if (r < 3) clock_ms = $urandom;
      else if (r < 6) clock_ms = clock_ms - $urandom_range(0, 3000);
      else clock_ms = clock_ms + $urandom_range(0, 250);
      s.now_ms = clock_ms;
      send_beat(s);
    end
  endtask

  // Receiver stalls in a pattern that changes mode at random
  always @(posedge clk_i) begin
    if ($urandom_range(0, 40) == 0) stall_mode <= ~stall_mode;
    out_ready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_checked++;
      if (pending_reactions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
      end else if (out_data_o !== pending_reactions[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch beat %0d: expected %p got %p", beats_checked,
                   pending_reactions[0], out_data_o);
        void'(pending_reactions.pop_front());
      end else begin
        void'(pending_reactions.pop_front());
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    mrs_in_t s;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // calm and zero-accel samples before cooldown end, then all extremes
    s = '{now_ms: 32'd0, accel_x: 16'sd0, accel_y: 16'sd2637, accel_z: 16'sd0,
          gyro_x: 16'sd0, gyro_y: 16'sd0, gyro_z: 16'sd0};
    rows.push_back('{s, 1'b1, PH_IDLE});
    s.accel_y = 16'sd0; s.now_ms = 32'd100;
    rows.push_back('{s, 1'b1, PH_IDLE});
    s = '{now_ms: 32'd499, accel_x: 16'h8000, accel_y: 16'h8000, accel_z: 16'h8000,
          gyro_x: 16'h8000, gyro_y: 16'h8000, gyro_z: 16'h8000};
    rows.push_back('{s, 1'b1, PH_IDLE});
    s.now_ms = 32'd500;
    rows.push_back('{s, 1'b1, PH_EXCITED});
    s = '{now_ms: 32'd700, accel_x: 16'h7fff, accel_y: 16'h7fff, accel_z: 16'h7fff,
          gyro_x: 16'h7fff, gyro_y: 16'h7fff, gyro_z: 16'h7fff};
    rows.push_back('{s, 1'b1, PH_TILT});
    s.now_ms = 32'd900;
    rows.push_back('{s, 1'b1, PH_DROP});
    s.now_ms = 32'd1100;
    rows.push_back('{s, 1'b1, PH_PEAK});
    s.now_ms = 32'd2100;
    rows.push_back('{s, 1'b1, PH_DIZZY});
    s.now_ms = 32'd2800;
    rows.push_back('{s, 1'b1, PH_HAPPY});
    s.now_ms = 32'd3600;
    rows.push_back('{s, 1'b1, PH_IDLE});
    // timestamp going backwards, zero accel, tilt path to settle
    s = '{now_ms: 32'hffff_fff0, accel_x: 16'sd0, accel_y: 16'sd0, accel_z: 16'sd0,
          gyro_x: 16'sd300, gyro_y: 16'sd0, gyro_z: 16'sd0};
    rows.push_back('{s, 1'b0, PH_IDLE});
    s.now_ms = 32'd4400;
    rows.push_back('{s, 1'b0, PH_IDLE});
    s.now_ms = 32'd100;
    rows.push_back('{s, 1'b0, PH_IDLE});
    s = '{now_ms: 32'd4700, accel_x: 16'sd0, accel_y: 16'sd2637, accel_z: 16'sd0,
          gyro_x: 16'sd0, gyro_y: 16'sd0, gyro_z: 16'sd0};
    for (int k = 0; k < 5; k++) begin
      rows.push_back('{s, 1'b0, PH_IDLE});
      s.now_ms += 32'd250;
    end
    s.accel_x = 16'sd1000;
    rows.push_back('{s, 1'b0, PH_IDLE});
    s.accel_x = 16'sd0; s.accel_y = 16'sh8001;
    rows.push_back('{s, 1'b0, PH_IDLE});

    foreach (rows[k]) begin
      row = rows[k];
      send_beat(row.smp);
      if (row.known && cur_phase != row.phase) begin
        mismatches++;
        $display("table row %0d: predictor phase %s, expected %s", k,
                 cur_phase.name(), row.phase.name());
      end
    end
    drain();
    clock_ms = 32'd10000;

    random_phase(400);
    drain();
    write_reg(CFG_GRAVITY_BASE, 16'd0);
    write_reg(CFG_MILD_RATE_LIM, 16'd0);
    write_reg(CFG_MILD_ACC_LIM, 16'd32767);
    write_reg(CFG_HARD_RATE_LIM, 16'hffff);
    write_reg(CFG_HARD_ACC_LIM, 16'd0);
    write_reg(CFG_TOP_RATE_LIM, 16'd0);
    write_reg(CFG_TOP_ACC_LIM, 16'd32767);
    write_reg(CFG_COOLDOWN_MS, 16'd0);
    cfg_we_i <= 1'b0;
    random_phase(300);
    drain();
    write_reg(CFG_GRAVITY_BASE, 16'd32767);
    write_reg(CFG_MILD_RATE_LIM, 16'd32767);
    write_reg(CFG_MILD_ACC_LIM, 16'd0);
    write_reg(CFG_HARD_RATE_LIM, 16'd0);
    write_reg(CFG_HARD_ACC_LIM, 16'd32767);
    write_reg(CFG_COOLDOWN_MS, 16'hffff);
    cfg_we_i <= 1'b0;
    random_phase(200);
    drain();
    write_reg(CFG_GRAVITY_BASE, 16'd2600);
    write_reg(CFG_MILD_RATE_LIM, 16'd150);
    write_reg(CFG_MILD_ACC_LIM, 16'd3000);
    write_reg(CFG_HARD_RATE_LIM, 16'd900);
    write_reg(CFG_HARD_ACC_LIM, 16'd3500);
    write_reg(CFG_COOLDOWN_MS, 16'd300);
    cfg_we_i <= 1'b0;
    random_phase(600);
    drain();

    $display("Fed %0d IMU samples over four register settings; %0d result beats checked.",
             fed, beats_checked);
    if (mismatches == 0 && pending_reactions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
